/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL; they expect i_clk and i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BPP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bpp_pkg.sv */
// ---------------------------------------------------------------------------
// bpp_pkg
// Word types, codes and saturating fixed-point helpers for the particle push.
// ---------------------------------------------------------------------------
package bpp_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int DT_W   = 31;
    localparam int MASS_W = 31;

    // s = t * 2^(FRAC_W+1) / denom: quotient bits and numerator width
    localparam int DIV_QB = WORD_W + 2;
    localparam int DIV_NB = WORD_W + FRAC_W + 2;

    // h = dt*q/(2m): quotient bits of the iterative divider
    localparam int HDIV_QB = 2 * WORD_W;

    typedef logic signed [WORD_W-1:0]   t_word;
    typedef t_word [2:0]                t_vec;
    typedef logic signed [2*WORD_W-1:0] t_prod;
    typedef t_prod [2:0]                t_pvec;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word FX_ONE   = t_word'(1) <<< FRAC_W;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_CHARGE    = 2'd1;
    localparam logic [1:0] CFG_MASS      = 2'd2;

    // side data that rides along the divider stages
    typedef struct packed {
        t_vec              pos;
        t_vec              vm;
        t_vec              eh;
        t_vec              vp;
        logic [WORD_W-1:0] dd;
        logic [2:0]        neg;
    } t_dcar;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // round a full product to the word, ties away from zero, then saturate
    function automatic t_word rnd_q(input t_prod p);
        t_prod bias;
        t_prod r;
        bias = t_prod'(1) <<< (FRAC_W - 1);
        if (p[2*WORD_W-1]) begin
            bias = bias - t_prod'(1);
        end
        r = (p + bias) >>> FRAC_W;
        if (r > t_prod'(WORD_MAX)) begin
            return WORD_MAX;
        end
        if (r < t_prod'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return r[WORD_W-1:0];
    endfunction

endpackage

/* src/boris_particle_push.sv */
// ---------------------------------------------------------------------------
// boris_particle_push
// One Boris step per particle: half kick, magnetic rotation, half kick, drift.
// ---------------------------------------------------------------------------
// The block takes one particle item per clock while o_stall is low and
// returns the advanced position and velocity, one result item per input
// item, in order. The pipeline advances as a whole: a stalled result
// freezes it, and empty stages fill while nothing waits at the output. All
// values are signed Q16.16 with round-to-nearest (ties away from zero) and
// saturation at every step. The factor h = dt*q/(2m) depends only on the
// configuration, so it is kept in a register and rebuilt by a
// one-bit-per-cycle divider after reset and after every configuration
// write; while it runs, o_stall stays high and no item is taken. The
// per-particle division s = 2t/(1+|t|^2) runs in a 34-stage pipelined
// restoring divider, three lanes wide, which sets most of the latency.
`include "assert_macros.svh"

module boris_particle_push (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  bpp_pkg::t_word       i_pos_x,
    input  bpp_pkg::t_word       i_pos_y,
    input  bpp_pkg::t_word       i_pos_z,
    input  bpp_pkg::t_word       i_vel_x,
    input  bpp_pkg::t_word       i_vel_y,
    input  bpp_pkg::t_word       i_vel_z,
    input  bpp_pkg::t_word       i_efield_x,
    input  bpp_pkg::t_word       i_efield_y,
    input  bpp_pkg::t_word       i_efield_z,
    input  bpp_pkg::t_word       i_bfield_x,
    input  bpp_pkg::t_word       i_bfield_y,
    input  bpp_pkg::t_word       i_bfield_z,
    // result item channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output bpp_pkg::t_word       o_new_pos_x,
    output bpp_pkg::t_word       o_new_pos_y,
    output bpp_pkg::t_word       o_new_pos_z,
    output bpp_pkg::t_word       o_new_vel_x,
    output bpp_pkg::t_word       o_new_vel_y,
    output bpp_pkg::t_word       o_new_vel_z
);
    import bpp_pkg::*;

    // pipeline positions of the valid bits
    localparam int ST_DIV0 = 8;                  // divider setup stage
    localparam int ST_K    = ST_DIV0 + DIV_QB + 1;
    localparam int NST     = ST_K + 8;           // through the output register

    // h update sequencer
    localparam logic [2:0] HS_IDLE = 3'd0;
    localparam logic [2:0] HS_MUL  = 3'd1;
    localparam logic [2:0] HS_INIT = 3'd2;
    localparam logic [2:0] HS_RUN  = 3'd3;
    localparam logic [2:0] HS_FIN  = 3'd4;

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [DT_W-1:0]   r_dt;
    t_word             r_charge;
    logic [MASS_W-1:0] r_mass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= DT_W'(655);
            r_charge <= FX_ONE;
            r_mass   <= MASS_W'(FX_ONE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP: r_dt     <= i_cfg_data[DT_W-1:0];
                CFG_CHARGE:    r_charge <= i_cfg_data;
                CFG_MASS:      r_mass   <= i_cfg_data[MASS_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // h = round(dt*q / (2m)) by restoring division, one bit per cycle.
    // Rounded as floor((2*|dt*q| + 2m) / 4m).
    // -----------------------------------------------------------------------
    logic [2:0]           r_hst;
    logic [2*WORD_W-2:0]  r_hprod;
    logic                 r_hneg;
    logic [HDIV_QB-1:0]   r_hnum;
    logic [MASS_W+1:0]    r_hrem;
    logic [HDIV_QB-1:0]   r_hquo;
    logic [5:0]           r_hcnt;
    t_word                r_hval;

    logic [WORD_W-1:0]    w_qmag;
    logic [MASS_W+2:0]    w_hsh;
    logic [MASS_W+2:0]    w_hden;
    logic                 w_hge;

    assign w_qmag = r_charge[WORD_W-1] ? WORD_W'(-r_charge) : WORD_W'(r_charge);
    assign w_hsh  = {r_hrem, r_hnum[HDIV_QB-1]};
    assign w_hden = {1'b0, r_mass, 2'b00};
    assign w_hge  = (w_hsh >= w_hden);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hst <= HS_MUL;
        end else if (i_cfg_we) begin
            r_hst <= HS_MUL;
        end else begin
            unique case (r_hst)
                HS_IDLE: r_hst <= HS_IDLE;
                HS_MUL:  r_hst <= HS_INIT;
                HS_INIT: r_hst <= HS_RUN;
                HS_RUN:  r_hst <= (r_hcnt == 6'(HDIV_QB - 1)) ? HS_FIN : HS_RUN;
                HS_FIN:  r_hst <= HS_IDLE;
                default: r_hst <= HS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_hst)
            HS_MUL: begin
                r_hprod <= {{(2*WORD_W-1-DT_W){1'b0}}, r_dt} *
                           {{(WORD_W-1){1'b0}}, w_qmag};
                r_hneg  <= r_charge[WORD_W-1];
            end
            HS_INIT: begin
                r_hnum <= {r_hprod, 1'b0} + HDIV_QB'({r_mass, 1'b0});
                r_hrem <= '0;
                r_hquo <= '0;
                r_hcnt <= '0;
            end
            HS_RUN: begin
                r_hnum <= r_hnum << 1;
                r_hquo <= {r_hquo[HDIV_QB-2:0], w_hge};
                r_hrem <= w_hge ? (MASS_W+2)'(w_hsh - w_hden) : w_hsh[MASS_W+1:0];
                r_hcnt <= r_hcnt + 6'd1;
            end
            HS_FIN: begin
                // zero mass: saturate toward the sign, zero when dt*q is zero
                if (r_mass == '0) begin
                    if (r_hprod == '0) begin
                        r_hval <= '0;
                    end else begin
                        r_hval <= r_hneg ? WORD_MIN : WORD_MAX;
                    end
                end else if (!r_hneg && (|r_hquo[HDIV_QB-1:WORD_W-1])) begin
                    r_hval <= WORD_MAX;
                end else if (r_hneg && ((|r_hquo[HDIV_QB-1:WORD_W]) ||
                             (r_hquo[WORD_W-1] && (|r_hquo[WORD_W-2:0])))) begin
                    r_hval <= WORD_MIN;
                end else begin
                    r_hval <= r_hneg ? -t_word'(r_hquo[WORD_W-1:0])
                                     :  t_word'(r_hquo[WORD_W-1:0]);
                end
            end
            default: ;
        endcase
    end

    // -----------------------------------------------------------------------
    // Pipeline control: advance everything unless a result is held
    // -----------------------------------------------------------------------
    logic           w_en;
    logic           w_acc;
    logic [NST-1:0] r_vld;

    assign w_en    = !r_vld[NST-1] || !i_stall;
    assign o_stall = !w_en || (r_hst != HS_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], w_acc};
        end
    end

    // -----------------------------------------------------------------------
    // Front: kick factor, rotation vector t, v- and v' = v- + v- x t
    // -----------------------------------------------------------------------
    t_vec  r_a_pos, r_a_vel, r_a_e, r_a_b;
    t_vec  r_b_pos, r_b_vel;
    t_pvec r_b_peh, r_b_pt;
    t_vec  r_c_pos, r_c_vel, r_c_eh, r_c_t;
    t_vec  r_d_pos, r_d_eh, r_d_t, r_d_vm;
    t_vec  r_e_pos, r_e_eh, r_e_t, r_e_vm;
    t_pvec r_e_psq;
    t_prod r_e_pc [0:5];
    t_vec  r_f_pos, r_f_eh, r_f_t, r_f_vm, r_f_sq;
    t_word r_f_c [0:5];
    t_vec  r_g_pos, r_g_eh, r_g_t, r_g_vm, r_g_c;
    t_word r_g_t2p, r_g_sq2;
    t_vec  r_h_pos, r_h_eh, r_h_t, r_h_vm, r_h_vp;
    t_word r_h_t2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage A: take the item
            r_a_pos <= {i_pos_z, i_pos_y, i_pos_x};
            r_a_vel <= {i_vel_z, i_vel_y, i_vel_x};
            r_a_e   <= {i_efield_z, i_efield_y, i_efield_x};
            r_a_b   <= {i_bfield_z, i_bfield_y, i_bfield_x};
            // stage B: E*h and B*h products
            r_b_pos <= r_a_pos;
            r_b_vel <= r_a_vel;
            for (int i = 0; i < 3; i++) begin
                r_b_peh[i] <= t_prod'(r_a_e[i]) * t_prod'(r_hval);
                r_b_pt[i]  <= t_prod'(r_a_b[i]) * t_prod'(r_hval);
            end
            // stage C: round
            r_c_pos <= r_b_pos;
            r_c_vel <= r_b_vel;
            for (int i = 0; i < 3; i++) begin
                r_c_eh[i] <= rnd_q(r_b_peh[i]);
                r_c_t[i]  <= rnd_q(r_b_pt[i]);
            end
            // stage D: first half kick
            r_d_pos <= r_c_pos;
            r_d_eh  <= r_c_eh;
            r_d_t   <= r_c_t;
            for (int i = 0; i < 3; i++) begin
                r_d_vm[i] <= sat_add(r_c_vel[i], r_c_eh[i]);
            end
            // stage E: |t|^2 terms and v- x t products
            r_e_pos <= r_d_pos;
            r_e_eh  <= r_d_eh;
            r_e_t   <= r_d_t;
            r_e_vm  <= r_d_vm;
            for (int i = 0; i < 3; i++) begin
                r_e_psq[i] <= t_prod'(r_d_t[i]) * t_prod'(r_d_t[i]);
            end
            r_e_pc[0] <= t_prod'(r_d_vm[1]) * t_prod'(r_d_t[2]);
            r_e_pc[1] <= t_prod'(r_d_vm[2]) * t_prod'(r_d_t[1]);
            r_e_pc[2] <= t_prod'(r_d_vm[2]) * t_prod'(r_d_t[0]);
            r_e_pc[3] <= t_prod'(r_d_vm[0]) * t_prod'(r_d_t[2]);
            r_e_pc[4] <= t_prod'(r_d_vm[0]) * t_prod'(r_d_t[1]);
            r_e_pc[5] <= t_prod'(r_d_vm[1]) * t_prod'(r_d_t[0]);
            // stage F: round
            r_f_pos <= r_e_pos;
            r_f_eh  <= r_e_eh;
            r_f_t   <= r_e_t;
            r_f_vm  <= r_e_vm;
            for (int i = 0; i < 3; i++) begin
                r_f_sq[i] <= rnd_q(r_e_psq[i]);
            end
            for (int k = 0; k < 6; k++) begin
                r_f_c[k] <= rnd_q(r_e_pc[k]);
            end
            // stage G: cross differences, first half of |t|^2
            r_g_pos <= r_f_pos;
            r_g_eh  <= r_f_eh;
            r_g_t   <= r_f_t;
            r_g_vm  <= r_f_vm;
            r_g_t2p <= sat_add(r_f_sq[0], r_f_sq[1]);
            r_g_sq2 <= r_f_sq[2];
            for (int i = 0; i < 3; i++) begin
                r_g_c[i] <= sat_sub(r_f_c[2*i], r_f_c[2*i+1]);
            end
            // stage H: v' and the full |t|^2
            r_h_pos <= r_g_pos;
            r_h_eh  <= r_g_eh;
            r_h_t   <= r_g_t;
            r_h_vm  <= r_g_vm;
            r_h_t2  <= sat_add(r_g_t2p, r_g_sq2);
            for (int i = 0; i < 3; i++) begin
                r_h_vp[i] <= sat_add(r_g_vm[i], r_g_c[i]);
            end
        end
    end

    // -----------------------------------------------------------------------
    // s = round(t * 2^(FRAC+1) / (1 + |t|^2)): three-lane pipelined divider.
    // Numerator 2*|t|*2^(FRAC+1) + d over divisor 2d gives the rounding.
    // -----------------------------------------------------------------------
    logic [WORD_W-1:0] r_dv_rem [0:DIV_QB-1][0:2];
    logic [DIV_QB-1:0] r_dv_low [0:DIV_QB-1][0:2];
    logic [DIV_QB-1:0] r_dv_quo [0:DIV_QB][0:2];
    t_dcar             r_dv_car [0:DIV_QB];

    t_word             w_denom;
    logic [DIV_NB-1:0] w_num [0:2];
    logic [WORD_W-1:0] w_tmag [0:2];
    t_dcar             w_car0;

    assign w_denom = sat_add(FX_ONE, r_h_t2);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_tmag[i] = r_h_t[i][WORD_W-1] ? WORD_W'(-r_h_t[i]) : WORD_W'(r_h_t[i]);
            w_num[i]  = {w_tmag[i], (FRAC_W+2)'(0)} + DIV_NB'(w_denom);
        end
        w_car0.pos = r_h_pos;
        w_car0.vm  = r_h_vm;
        w_car0.eh  = r_h_eh;
        w_car0.vp  = r_h_vp;
        w_car0.dd  = {w_denom[WORD_W-2:0], 1'b0};
        w_car0.neg = {r_h_t[2][WORD_W-1], r_h_t[1][WORD_W-1], r_h_t[0][WORD_W-1]};
    end

    logic [WORD_W-1:0] n_dv_rem [0:DIV_QB-1][0:2];
    logic              n_dv_bit [0:DIV_QB-1][0:2];

    always_comb begin
        logic [WORD_W:0] sh;
        logic [WORD_W:0] dd;
        for (int j = 0; j < DIV_QB; j++) begin
            for (int l = 0; l < 3; l++) begin
                sh = {r_dv_rem[j][l], r_dv_low[j][l][DIV_QB-1]};
                dd = {1'b0, r_dv_car[j].dd};
                n_dv_bit[j][l] = (sh >= dd);
                n_dv_rem[j][l] = n_dv_bit[j][l] ? WORD_W'(sh - dd) : sh[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_car[0] <= w_car0;
            for (int l = 0; l < 3; l++) begin
                r_dv_rem[0][l] <= WORD_W'(w_num[l][DIV_NB-1:DIV_QB]);
                r_dv_low[0][l] <= w_num[l][DIV_QB-1:0];
                r_dv_quo[0][l] <= '0;
            end
            for (int j = 0; j < DIV_QB; j++) begin
                r_dv_car[j+1] <= r_dv_car[j];
                for (int l = 0; l < 3; l++) begin
                    r_dv_quo[j+1][l] <= {r_dv_quo[j][l][DIV_QB-2:0], n_dv_bit[j][l]};
                    if (j < DIV_QB - 1) begin
                        r_dv_rem[j+1][l] <= n_dv_rem[j][l];
                        r_dv_low[j+1][l] <= r_dv_low[j][l] << 1;
                    end
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Back: v+ = v- + v' x s, second half kick, drift
    // -----------------------------------------------------------------------
    t_dcar w_dv_out;
    assign w_dv_out = r_dv_car[DIV_QB];

    t_vec  r_k_pos, r_k_vm, r_k_eh, r_k_vp, r_k_s;
    t_vec  r_l_pos, r_l_vm, r_l_eh;
    t_prod r_l_pc [0:5];
    t_vec  r_m_pos, r_m_vm, r_m_eh;
    t_word r_m_c [0:5];
    t_vec  r_n_pos, r_n_vm, r_n_eh, r_n_c;
    t_vec  r_o_pos, r_o_vn;
    t_vec  r_p_pos, r_p_vn;
    t_pvec r_p_pd;
    t_vec  r_q_pos, r_q_vn, r_q_d;
    t_vec  r_out_pos, r_out_vel;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage K: sign and saturate s
            r_k_pos <= w_dv_out.pos;
            r_k_vm  <= w_dv_out.vm;
            r_k_eh  <= w_dv_out.eh;
            r_k_vp  <= w_dv_out.vp;
            for (int i = 0; i < 3; i++) begin
                if (!w_dv_out.neg[i] && (|r_dv_quo[DIV_QB][i][DIV_QB-1:WORD_W-1])) begin
                    r_k_s[i] <= WORD_MAX;
                end else if (w_dv_out.neg[i] &&
                             ((|r_dv_quo[DIV_QB][i][DIV_QB-1:WORD_W]) ||
                              (r_dv_quo[DIV_QB][i][WORD_W-1] &&
                               (|r_dv_quo[DIV_QB][i][WORD_W-2:0])))) begin
                    r_k_s[i] <= WORD_MIN;
                end else begin
                    r_k_s[i] <= w_dv_out.neg[i] ? -t_word'(r_dv_quo[DIV_QB][i][WORD_W-1:0])
                                                :  t_word'(r_dv_quo[DIV_QB][i][WORD_W-1:0]);
                end
            end
            // stage L: v' x s products
            r_l_pos   <= r_k_pos;
            r_l_vm    <= r_k_vm;
            r_l_eh    <= r_k_eh;
            r_l_pc[0] <= t_prod'(r_k_vp[1]) * t_prod'(r_k_s[2]);
            r_l_pc[1] <= t_prod'(r_k_vp[2]) * t_prod'(r_k_s[1]);
            r_l_pc[2] <= t_prod'(r_k_vp[2]) * t_prod'(r_k_s[0]);
            r_l_pc[3] <= t_prod'(r_k_vp[0]) * t_prod'(r_k_s[2]);
            r_l_pc[4] <= t_prod'(r_k_vp[0]) * t_prod'(r_k_s[1]);
            r_l_pc[5] <= t_prod'(r_k_vp[1]) * t_prod'(r_k_s[0]);
            // stage M: round
            r_m_pos <= r_l_pos;
            r_m_vm  <= r_l_vm;
            r_m_eh  <= r_l_eh;
            for (int k = 0; k < 6; k++) begin
                r_m_c[k] <= rnd_q(r_l_pc[k]);
            end
            // stage N: cross differences
            r_n_pos <= r_m_pos;
            r_n_vm  <= r_m_vm;
            r_n_eh  <= r_m_eh;
            for (int i = 0; i < 3; i++) begin
                r_n_c[i] <= sat_sub(r_m_c[2*i], r_m_c[2*i+1]);
            end
            // stage O: v+ and second half kick
            r_o_pos <= r_n_pos;
            for (int i = 0; i < 3; i++) begin
                r_o_vn[i] <= sat_add(sat_add(r_n_vm[i], r_n_c[i]), r_n_eh[i]);
            end
            // stage P: v*dt products
            r_p_pos <= r_o_pos;
            r_p_vn  <= r_o_vn;
            for (int i = 0; i < 3; i++) begin
                r_p_pd[i] <= t_prod'(r_o_vn[i]) * t_prod'(t_word'({1'b0, r_dt}));
            end
            // stage Q: round
            r_q_pos <= r_p_pos;
            r_q_vn  <= r_p_vn;
            for (int i = 0; i < 3; i++) begin
                r_q_d[i] <= rnd_q(r_p_pd[i]);
            end
            // stage R: drift into the output register
            r_out_vel <= r_q_vn;
            for (int i = 0; i < 3; i++) begin
                r_out_pos[i] <= sat_add(r_q_pos[i], r_q_d[i]);
            end
        end
    end

    assign o_new_pos_x = r_out_pos[0];
    assign o_new_pos_y = r_out_pos[1];
    assign o_new_pos_z = r_out_pos[2];
    assign o_new_vel_x = r_out_vel[0];
    assign o_new_vel_y = r_out_vel[1];
    assign o_new_vel_z = r_out_vel[2];

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `BPP_ASSERT_IMPL(a_hbusy_hold, r_hst != HS_IDLE, o_stall, "item taken while h rebuilds")
    `BPP_ASSERT_NEXT(a_cfg_restart, i_cfg_we, r_hst == HS_MUL, "h rebuild not restarted")
    `BPP_ASSERT_NEXT(a_freeze, !w_en, r_vld == $past(r_vld), "valid bits moved while frozen")

endmodule
